[design/bitmap_frame_allocator_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap frame allocator
// Shorthands for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication
`define BFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, constants and helpers of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Default sizing
    localparam int unsigned NUM_FRAMES_DEF = 1024;
    localparam int unsigned PAGE_SHIFT_DEF = 12;

    // Fixed field widths
    localparam int ADDR_W = 22;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [7:0]       BYTE_FULL = 8'hFF;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_WR,
        ST_RESP
    } t_state;

    // Position of the lowest clear bit in a byte (byte must not be full)
    function automatic logic [2:0] lowest_clear(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (!b[j]) begin
                pos = 3'(j);
            end
        end
        return pos;
    endfunction

endpackage

[design/bfa_bitmap_ram.sv]
// ----------------------------------------------------------------------------
// bfa_bitmap_ram
// Bitmap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfa_bitmap_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/bitmap_frame_allocator_top.sv]
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit page frame allocator over a one-bit-per-frame bitmap in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall): i_kind selects allocate or
//   free; i_address names the page to free. One request is worked at a time.
//   Response channel (o_out_valid / i_out_stall): one response per request
//   with ok, the allocated page address and the frame count afterwards.
//   Config channel (i_cfg_valid / o_cfg_ready): writes frame_limit; ready is
//   always high, writes belong between requests.
// Timing:
//   Free: read, write back, then output; an out-of-range page goes straight to output.
//   Allocate: the scan reads one bitmap byte per cycle from byte 0, over at
//   most min(frame_limit/8, NUM_FRAMES/8) bytes; a full count goes straight
//   to output. The next request is accepted the cycle after the response is
//   loaded into the output register.
// Reset:
//   A clearing pass writes every bitmap byte to zero, one byte per cycle,
//   with requests stalled. frame_limit resets to NUM_FRAMES, the count to zero.
// Stall:
//   A stalled response holds in the output register; a finished request waits
//   in the result registers till the output frees up; the input stays stalled.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top
    import bfa_pkg::*;
#(
    parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_address,
    // response
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_ok,
    output logic [ADDR_W-1:0] o_frame_address,
    output logic [CNT_W-1:0]  o_used_count,
    // config
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    localparam int unsigned BYTES = (NUM_FRAMES + 7) / 8;
    localparam int unsigned WHOLE = NUM_FRAMES / 8;
    localparam int unsigned AW    = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int unsigned NBW   = $clog2(WHOLE + 1);
    localparam int unsigned LW    = (NBW > 8) ? NBW : 8;
    localparam int unsigned SHW   = AW + 3 + ADDR_W;

    // Control registers
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_limit, n_limit;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [AW-1:0]     r_clr_idx, n_clr_idx;
    logic [LW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_rd_pend, n_rd_pend;
    logic              r_out_valid, n_out_valid;

    // Payload registers
    logic [AW-1:0]     r_chk_idx, n_chk_idx;
    logic [LW-1:0]     r_nbytes, n_nbytes;
    logic [AW-1:0]     r_byte_idx, n_byte_idx;
    logic [2:0]        r_bit, n_bit;
    logic              r_res_ok, n_res_ok;
    logic [ADDR_W-1:0] r_res_faddr, n_res_faddr;
    logic              r_out_ok, n_out_ok;
    logic [ADDR_W-1:0] r_out_faddr, n_out_faddr;
    logic [CNT_W-1:0]  r_out_count, n_out_count;

    // RAM ports
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;

    // Helpers
    logic              in_accept;
    logic [ADDR_W-1:0] free_frame;
    logic              free_in_range;
    logic [LW-1:0]     lim_bytes;
    logic [LW-1:0]     scan_bytes;
    logic [2:0]        hit_bit;
    logic [SHW-1:0]    hit_shifted;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  count_dec;

    bfa_bitmap_ram #(
        .DEPTH (BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall      = (r_state != ST_IDLE);
    assign in_accept       = i_in_valid && !o_in_stall;
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_out_ok;
    assign o_frame_address = r_out_faddr;
    assign o_used_count    = r_out_count;

    // Frame decode for a free request
    assign free_frame    = i_address >> PAGE_SHIFT;
    assign free_in_range = (free_frame < ADDR_W'(NUM_FRAMES));

    // Scan bound: whole bytes below the limit, capped at the bitmap size
    assign lim_bytes  = LW'(r_limit[CNT_W-1:3]);
    assign scan_bytes = (lim_bytes < LW'(WHOLE)) ? lim_bytes : LW'(WHOLE);

    // Hit in the byte just read
    assign hit_bit     = lowest_clear(rd_data);
    assign hit_shifted = SHW'({r_chk_idx, hit_bit}) << PAGE_SHIFT;

    // Saturating count steps
    assign count_inc = (r_count != COUNT_MAX) ? r_count + CNT_W'(1) : r_count;
    assign count_dec = (r_count != '0) ? r_count - CNT_W'(1) : r_count;

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_count     = r_count;
        n_clr_idx   = r_clr_idx;
        n_rd_idx    = r_rd_idx;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_chk_idx   = r_chk_idx;
        n_nbytes    = r_nbytes;
        n_byte_idx  = r_byte_idx;
        n_bit       = r_bit;
        n_res_ok    = r_res_ok;
        n_res_faddr = r_res_faddr;
        n_out_ok    = r_out_ok;
        n_out_faddr = r_out_faddr;
        n_out_count = r_out_count;
        wr_en       = 1'b0;
        wr_addr     = r_clr_idx;
        wr_data     = 8'h00;
        rd_en       = 1'b0;
        rd_addr     = r_rd_idx[AW-1:0];

        // Config write
        if (i_cfg_valid && o_cfg_ready) begin
            n_limit = i_cfg_data;
        end

        // Response taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // Zero the bitmap after reset
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_idx;
                wr_data = 8'h00;
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            // Take a request
            ST_IDLE: begin
                if (in_accept) begin
                    n_res_ok    = 1'b0;
                    n_res_faddr = '0;
                    if (i_kind == KIND_FREE) begin
                        if (free_in_range) begin
                            rd_en      = 1'b1;
                            rd_addr    = free_frame[AW+2:3];
                            n_byte_idx = free_frame[AW+2:3];
                            n_bit      = free_frame[2:0];
                            n_state    = ST_FREE_WR;
                        end else begin
                            n_state = ST_RESP;
                        end
                    end else begin
                        if (r_count == r_limit || scan_bytes == '0) begin
                            n_state = ST_RESP;
                        end else begin
                            n_nbytes  = scan_bytes;
                            n_rd_idx  = '0;
                            n_rd_pend = 1'b0;
                            n_state   = ST_SCAN;
                        end
                    end
                end
            end

            // Byte-per-cycle first-fit scan
            ST_SCAN: begin
                if (r_rd_pend && rd_data != BYTE_FULL) begin
                    wr_en       = 1'b1;
                    wr_addr     = r_chk_idx;
                    wr_data     = rd_data | (8'b1 << hit_bit);
                    n_count     = count_inc;
                    n_res_ok    = 1'b1;
                    n_res_faddr = hit_shifted[ADDR_W-1:0];
                    n_rd_pend   = 1'b0;
                    n_state     = ST_RESP;
                end else if (r_rd_idx < r_nbytes) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_rd_idx[AW-1:0];
                    n_chk_idx = r_rd_idx[AW-1:0];
                    n_rd_idx  = r_rd_idx + LW'(1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    n_state   = ST_RESP;
                end
            end

            // Clear the freed bit
            ST_FREE_WR: begin
                wr_en    = 1'b1;
                wr_addr  = r_byte_idx;
                wr_data  = rd_data & ~(8'b1 << r_bit);
                n_count  = count_dec;
                n_res_ok = 1'b1;
                n_state  = ST_RESP;
            end

            // Load the output register once it is free
            ST_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_faddr = r_res_faddr;
                    n_out_count = r_count;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_limit     <= CNT_W'(NUM_FRAMES);
            r_count     <= '0;
            r_clr_idx   <= '0;
            r_rd_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_count     <= n_count;
            r_clr_idx   <= n_clr_idx;
            r_rd_idx    <= n_rd_idx;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_chk_idx   <= n_chk_idx;
        r_nbytes    <= n_nbytes;
        r_byte_idx  <= n_byte_idx;
        r_bit       <= n_bit;
        r_res_ok    <= n_res_ok;
        r_res_faddr <= n_res_faddr;
        r_out_ok    <= n_out_ok;
        r_out_faddr <= n_out_faddr;
        r_out_count <= n_out_count;
    end

    // Assertions
    `include "bitmap_frame_allocator_top_assert.svh"

    `BFA_ASSERT_SAME(a_clear_blocks, r_state == ST_CLEAR, o_in_stall, "request taken during clear")
    `BFA_ASSERT_SAME(a_scan_bound, r_state == ST_SCAN, r_rd_idx <= r_nbytes, "scan past bound")
    `BFA_ASSERT_NEXT(a_free_path, in_accept && i_kind == KIND_FREE && free_in_range, r_state == ST_FREE_WR, "free skipped write")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the bitmap frame allocator against a cycle-free model of its bitmap,
// frame count and frame limit. Directed requests cover the first-fit order,
// address offsets, redundant frees and the frame limit corners. Random
// allocate/free traffic then runs over several limits, mostly with bursty
// idling on both channels. Every response is compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
    import bfa_pkg::*;
();

    localparam int unsigned NUM_FRAMES    = NUM_FRAMES_DEF;
    localparam int unsigned PAGE_SHIFT    = PAGE_SHIFT_DEF;
    localparam int unsigned MAP_BYTES     = (NUM_FRAMES + 7) / 8;
    localparam int unsigned WHOLE_BYTES   = NUM_FRAMES / 8;
    localparam int unsigned SETTLE_CYCLES = WHOLE_BYTES + 16;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SHOW_LIMIT    = 10;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] frame_address;
        logic [CNT_W-1:0]  used_count;
    } t_frame_response;

    // DUT ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_kind = KIND_ALLOC;
    logic [ADDR_W-1:0] i_address = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_ok;
    logic [ADDR_W-1:0] o_frame_address;
    logic [CNT_W-1:0]  o_used_count;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data = '0;

    // Model state: bitmap, frames in use, frame limit
    logic [7:0]        frame_map [MAP_BYTES];
    logic [CNT_W-1:0]  frames_used;
    logic [CNT_W-1:0]  frame_limit_q;

    t_frame_response   awaited_responses [$];
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       stall_left = 0;
    bit                idle_on = 1'b1;

    bitmap_frame_allocator_top #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_address       (i_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ok            (o_ok),
        .o_frame_address (o_frame_address),
        .o_used_count    (o_used_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Response side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endtask

    // Compare each accepted response with the oldest awaited one
    always @(posedge i_clk) begin : check_responses
        t_frame_response want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (awaited_responses.size() == 0) begin
                note_mismatch("unexpected response, used_count", 0, o_used_count);
            end else begin
                want = awaited_responses.pop_front();
                if (o_ok !== want.ok)
                    note_mismatch("ok", want.ok, o_ok);
                if (o_frame_address !== want.frame_address)
                    note_mismatch("frame_address", want.frame_address, o_frame_address);
                if (o_used_count !== want.used_count)
                    note_mismatch("used_count", want.used_count, o_used_count);
            end
        end
    end

    // Apply one request to the model bitmap and return the response it gives
    function automatic t_frame_response apply_request(input logic kind,
                                                      input logic [ADDR_W-1:0] addr);
        t_frame_response r;
        int unsigned     span;
        int unsigned     frame;
        bit              found;
        r = '0;
        found = 1'b0;
        frame = 0;
        if (kind == KIND_ALLOC) begin
            span = frame_limit_q / 8;
            if (span > WHOLE_BYTES)
                span = WHOLE_BYTES;
            // first fit over whole bytes below the limit, full bytes skipped
            if (frames_used != frame_limit_q) begin
                for (int i = 0; i < span; i++) begin
                    if (!found && frame_map[i] != BYTE_FULL) begin
                        for (int j = 0; j < 8; j++) begin
                            if (!found && !frame_map[i][j]) begin
                                found = 1'b1;
                                frame = i * 8 + j;
                            end
                        end
                    end
                end
            end
            if (found) begin
                frame_map[frame / 8][frame % 8] = 1'b1;
                if (frames_used != COUNT_MAX)
                    frames_used = frames_used + 1'b1;
                r.ok = 1'b1;
                r.frame_address = ADDR_W'(frame << PAGE_SHIFT);
            end
        end else begin
            // free clears the bit even if clear; count drops, floor 0
            frame = addr >> PAGE_SHIFT;
            if (frame < NUM_FRAMES) begin
                frame_map[frame / 8][frame % 8] = 1'b0;
                if (frames_used != 0)
                    frames_used = frames_used - 1'b1;
                r.ok = 1'b1;
            end
        end
        r.used_count = frames_used;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] page_address(input int unsigned frame,
                                                       input logic [PAGE_SHIFT-1:0] offset);
        return ADDR_W'((frame << PAGE_SHIFT) | offset);
    endfunction

    // Send one request; valid stays high so a following request goes back to back
    task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_address  <= addr;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        awaited_responses.push_back(apply_request(kind, addr));
    endtask

    task automatic end_requests();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_for_responses();
        while (awaited_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_frame_limit(input logic [CNT_W-1:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        frame_limit_q = limit;
    endtask

    // First-fit order, offsets below the page, redundant frees, count floor
    task automatic test_first_requests();
        send_request(KIND_FREE, '0);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '1);
        send_request(KIND_FREE, page_address(1, '1));
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, '1);
        send_request(KIND_ALLOC, '0);
    endtask

    // Frame limit corners: zero, partial byte, beyond the bitmap, count above
    // the limit, count equal to the limit
    task automatic test_limit_corners();
        end_requests();
        wait_for_responses();
        write_frame_limit('0);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, page_address(0, '0));

        end_requests();
        wait_for_responses();
        write_frame_limit(CNT_W'(13));
        repeat (7) send_request(KIND_ALLOC, '0);

        end_requests();
        wait_for_responses();
        write_frame_limit(COUNT_MAX);
        repeat (3) send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, page_address(2, '0));

        end_requests();
        wait_for_responses();
        write_frame_limit(CNT_W'(8));
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, page_address(4, '0));

        end_requests();
        wait_for_responses();
        write_frame_limit(frames_used);
        send_request(KIND_ALLOC, '0);

        end_requests();
        wait_for_responses();
        write_frame_limit(CNT_W'(NUM_FRAMES));
        send_request(KIND_ALLOC, '0);
    endtask

    // Random traffic under one limit; alternating fill and release stretches
    task automatic test_random_traffic(input logic [CNT_W-1:0] limit,
                                       input int unsigned count, input bit with_idling);
        int unsigned       alloc_pct;
        int unsigned       hi;
        int unsigned       pick;
        logic [ADDR_W-1:0] addr;
        end_requests();
        wait_for_responses();
        idle_on = with_idling;
        write_frame_limit(limit);
        for (int unsigned n = 0; n < count; n++) begin
            alloc_pct = ((n / 50) % 2 == 0) ? 75 : 35;
            if ($urandom_range(0, 99) < alloc_pct) begin
                send_request(KIND_ALLOC, ADDR_W'($urandom));
            end else begin
                // mostly frees near the allocated low frames
                pick = $urandom_range(0, 9);
                hi = frames_used + 16;
                if (hi > NUM_FRAMES - 1)
                    hi = NUM_FRAMES - 1;
                if (pick < 6)
                    addr = page_address($urandom_range(0, hi), PAGE_SHIFT'($urandom));
                else if (pick < 9)
                    addr = page_address($urandom_range(0, NUM_FRAMES - 1),
                                        PAGE_SHIFT'($urandom));
                else
                    addr = ADDR_W'($urandom);
                send_request(KIND_FREE, addr);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < MAP_BYTES; i++)
            frame_map[i] = '0;
        frames_used = '0;
        frame_limit_q = CNT_W'(NUM_FRAMES);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_requests();
        test_limit_corners();
        test_random_traffic(COUNT_MAX, 150, 1'b1);
        test_random_traffic(CNT_W'(64), 150, 1'b1);
        test_random_traffic('0, 50, 1'b1);
        test_random_traffic(CNT_W'(300), 150, 1'b1);
        test_random_traffic(CNT_W'($urandom_range(0, 2047)), 150, 1'b1);
        test_random_traffic(CNT_W'(8), 100, 1'b1);
        test_random_traffic(CNT_W'(NUM_FRAMES), 300, 1'b0);

        end_requests();
        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/bfa_pkg.sv
design/bfa_bitmap_ram.sv
design/bitmap_frame_allocator_top.sv
verif/testbench.sv
